// File: design/bmhq_pkg.sv
// shared constants and codes for the binary min-heap queue
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

  // default sizing
  localparam int CAPACITY_DEF     = 64;
  localparam int PAYLOAD_BITS_DEF = 32;

  // priority key width
  localparam int PRIO_BITS = 16;

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_EMPTY      = 2'd2;
  localparam logic [1:0] ST_UNUSED     = 2'd3;

endpackage
`default_nettype wire

// File: design/bmhq_ram.sv
// heap entry store: one write port, two registered read ports
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
  parameter int DEPTH = bmhq_pkg::CAPACITY_DEF,
  parameter int WIDTH = bmhq_pkg::PRIO_BITS + bmhq_pkg::PAYLOAD_BITS_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  output logic      [WIDTH-1:0] rdata_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, registered: data comes in the cycle after the address
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

// File: design/binary_min_heap_queue.sv
// binary min-heap priority queue: sequencer, shared comparator and heap store
//
//  channel   | handshake       | payload
//  ----------+-----------------+-----------------------------------------------
//  request   | start / busy    | req_type, in_priority, in_payload
//  result    | done (1 cycle)  | status, out_priority, out_payload,
//            |                 | entry_count, is_empty
//
// a rejected word raises done the cycle after it is accepted; otherwise busy
// stays high while the entry moves up (insert) or down (remove), then done; the
// entry moves up to log2 CAPACITY levels; a level is a store read and
// a compare, plus a child-select compare on a remove, all on one comparator
// rst is synchronous; it empties the heap, the store itself is not cleared
// busy is high from an accepted word until done, but not for a rejected word; done can not be held off
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue #(
  parameter int CAPACITY     = bmhq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF,
  localparam int CW          = $clog2(CAPACITY + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 req_type,
  input  wire logic signed [bmhq_pkg::PRIO_BITS-1:0] in_priority,
  input  wire logic        [PAYLOAD_BITS-1:0]       in_payload,
  output logic                                      done,
  output logic             [1:0]                    status,
  output logic signed      [bmhq_pkg::PRIO_BITS-1:0] out_priority,
  output logic             [PAYLOAD_BITS-1:0]       out_payload,
  output logic             [CW-1:0]                 entry_count,
  output logic                                      is_empty
);

  localparam int PB = bmhq_pkg::PRIO_BITS;
  localparam int EW = PB + PAYLOAD_BITS;
  localparam int AW = $clog2(CAPACITY);
  localparam int IW = AW + 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_UP_CHK = 7'b0000010,
    S_UP_CMP = 7'b0000100,
    S_RM_LD  = 7'b0001000,
    S_DN_CHK = 7'b0010000,
    S_DN_SEL = 7'b0100000,
    S_DN_CMP = 7'b1000000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count;
  logic [AW-1:0]   cur;
  logic [EW-1:0]   hold;
  logic [EW-1:0]   cand;
  logic [AW-1:0]   cand_idx;
  logic            rv;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [EW-1:0]   mem_wdata;
  logic [AW-1:0]   raddr_a;
  logic [AW-1:0]   raddr_b;
  logic [EW-1:0]   rdata_a;
  logic [EW-1:0]   rdata_b;

  logic [IW-1:0]   left_w;
  logic [IW-1:0]   right_w;
  logic [IW-1:0]   count_w;
  logic            left_ok;
  logic            right_ok;
  logic [AW-1:0]   left_a;
  logic [AW-1:0]   right_a;
  logic [AW-1:0]   parent_a;
  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_p1;

  logic signed [PB-1:0] cmp_a;
  logic signed [PB-1:0] cmp_b;
  logic                 lt;

  assign busy = (state != S_IDLE);

  // child and parent indexes of the current slot
  assign left_w   = {cur, 1'b1};
  assign right_w  = left_w + IW'(1);
  assign count_w  = IW'(count);
  assign left_ok  = (left_w < count_w);
  assign right_ok = (right_w < count_w);
  assign left_a   = left_w[AW-1:0];
  assign right_a  = right_ok ? right_w[AW-1:0] : left_a;
  assign parent_a = AW'((cur - AW'(1)) >> 1);
  assign cnt_m1   = count - CW'(1);
  assign cnt_p1   = count + CW'(1);

  // shared priority comparator
  always_comb begin
    case (state)
      S_UP_CMP: begin
        cmp_a = hold[EW-1 -: PB];
        cmp_b = rdata_a[EW-1 -: PB];
      end
      S_DN_SEL: begin
        cmp_a = rdata_b[EW-1 -: PB];
        cmp_b = rdata_a[EW-1 -: PB];
      end
      default: begin
        cmp_a = cand[EW-1 -: PB];
        cmp_b = hold[EW-1 -: PB];
      end
    endcase
  end
  assign lt = (cmp_a < cmp_b);

  // store read addresses
  always_comb begin
    raddr_a = '0;
    raddr_b = cnt_m1[AW-1:0];
    case (state)
      S_UP_CHK: begin
        raddr_a = parent_a;
      end
      S_DN_CHK: begin
        raddr_a = left_a;
        raddr_b = right_a;
      end
      default: begin
        raddr_a = '0;
        raddr_b = cnt_m1[AW-1:0];
      end
    endcase
  end

  // store write: the moving entry stays in hold, others shift by one level
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur;
    mem_wdata = hold;
    case (state)
      S_UP_CHK: begin
        mem_we = (cur == '0);
      end
      S_UP_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = lt ? rdata_a : hold;
      end
      S_DN_CHK: begin
        mem_we = !left_ok;
      end
      S_DN_CMP: begin
        mem_we    = 1'b1;
        mem_wdata = lt ? cand : hold;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  bmhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (EW)
  ) u_ram (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            out_priority <= '0;
            out_payload  <= '0;
            if (req_type == bmhq_pkg::REQ_INSERT) begin
              if (count_w >= IW'(CAPACITY)) begin
                done        <= 1'b1;
                status      <= bmhq_pkg::ST_FULL;
                entry_count <= count;
                is_empty    <= (count == '0);
              end else begin
                hold  <= {in_priority, in_payload};
                cur   <= count[AW-1:0];
                state <= S_UP_CHK;
              end
            end else begin
              if (count == '0) begin
                done        <= 1'b1;
                status      <= bmhq_pkg::ST_EMPTY;
                entry_count <= count;
                is_empty    <= 1'b1;
              end else begin
                count <= cnt_m1;
                state <= S_RM_LD;
              end
            end
          end
        end
        S_UP_CHK: begin
          if (cur == '0) begin
            count       <= cnt_p1;
            done        <= 1'b1;
            status      <= bmhq_pkg::ST_OK;
            entry_count <= cnt_p1;
            is_empty    <= 1'b0;
            state       <= S_IDLE;
          end else begin
            cand_idx <= parent_a;
            state    <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (lt) begin
            cur   <= cand_idx;
            state <= S_UP_CHK;
          end else begin
            count       <= cnt_p1;
            done        <= 1'b1;
            status      <= bmhq_pkg::ST_OK;
            entry_count <= cnt_p1;
            is_empty    <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_RM_LD: begin
          // root goes out, last entry starts its walk down from the root
          out_priority <= rdata_a[EW-1 -: PB];
          out_payload  <= rdata_a[PAYLOAD_BITS-1:0];
          hold         <= rdata_b;
          cur          <= '0;
          state        <= S_DN_CHK;
        end
        S_DN_CHK: begin
          if (!left_ok) begin
            done        <= 1'b1;
            status      <= bmhq_pkg::ST_OK;
            entry_count <= count;
            is_empty    <= (count == '0);
            state       <= S_IDLE;
          end else begin
            rv    <= right_ok;
            state <= S_DN_SEL;
          end
        end
        S_DN_SEL: begin
          // right child only when strictly smaller, ties go left
          if (rv && lt) begin
            cand     <= rdata_b;
            cand_idx <= right_a;
          end else begin
            cand     <= rdata_a;
            cand_idx <= left_a;
          end
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (lt) begin
            cur   <= cand_idx;
            state <= S_DN_CHK;
          end else begin
            done        <= 1'b1;
            status      <= bmhq_pkg::ST_OK;
            entry_count <= count;
            is_empty    <= (count == '0);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: dv/binary_min_heap_queue_tb.sv
// self-checking testbench for the binary min-heap queue
`timescale 1ns / 1ps
module binary_min_heap_queue_tb;

  localparam int HEAP_DEPTH  = 64;
  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 1300;

  typedef struct {
    logic signed [15:0] prio;
    logic        [31:0] data;
  } heap_slot_t;

  typedef struct {
    logic        [1:0]  status;
    logic signed [15:0] prio;
    logic        [31:0] data;
    logic        [6:0]  count;
    logic               empty;
  } heap_result_t;

  typedef struct {
    logic               req;
    logic signed [15:0] prio;
    logic        [31:0] data;
    bit                 typed;
    heap_result_t       want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic req_type = bmhq_pkg::REQ_INSERT;
  logic signed [15:0] in_priority = '0;
  logic [31:0] in_payload = '0;
  logic busy;
  logic done;
  logic [1:0] status;
  logic signed [15:0] out_priority;
  logic [31:0] out_payload;
  logic [6:0] entry_count;
  logic is_empty;

  // heap mirror and expected results
  heap_slot_t   heap_mirror [HEAP_DEPTH];
  int           heap_used = 0;
  heap_result_t pending_results [$];
  stim_row_t    directed_rows [$];
  int           fault_count = 0;
  int           stall_cycles = 0;

  binary_min_heap_queue dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .in_priority  (in_priority),
    .in_payload   (in_payload),
    .done         (done),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  // apply one word to the heap mirror and return the result it causes
  function automatic heap_result_t heap_apply(logic req, logic signed [15:0] prio,
                                              logic [31:0] data);
    heap_result_t res;
    heap_slot_t   tmp;
    int           cur;
    int           par;
    int           left;
    int           sel;
    res.status = bmhq_pkg::ST_OK;
    res.prio   = '0;
    res.data   = '0;
    if (req == bmhq_pkg::REQ_INSERT) begin
      if (heap_used >= HEAP_DEPTH) begin
        res.status = bmhq_pkg::ST_FULL;
      end else begin
        cur = heap_used;
        heap_mirror[cur].prio = prio;
        heap_mirror[cur].data = data;
        // sift up while strictly smaller than the parent
        while (cur > 0) begin
          par = (cur - 1) / 2;
          if (heap_mirror[cur].prio < heap_mirror[par].prio) begin
            tmp = heap_mirror[cur];
            heap_mirror[cur] = heap_mirror[par];
            heap_mirror[par] = tmp;
            cur = par;
          end else begin
            break;
          end
        end
        heap_used++;
      end
    end else begin
      if (heap_used == 0) begin
        res.status = bmhq_pkg::ST_EMPTY;
      end else begin
        res.prio = heap_mirror[0].prio;
        res.data = heap_mirror[0].data;
        heap_used--;
        heap_mirror[0] = heap_mirror[heap_used];
        par = 0;
        // sift down toward the smaller child, ties go left
        forever begin
          left = 2 * par + 1;
          if (left >= heap_used) break;
          sel = left;
          if (left + 1 < heap_used && heap_mirror[left].prio > heap_mirror[left + 1].prio)
            sel = left + 1;
          if (heap_mirror[sel].prio < heap_mirror[par].prio) begin
            tmp = heap_mirror[sel];
            heap_mirror[sel] = heap_mirror[par];
            heap_mirror[par] = tmp;
            par = sel;
          end else begin
            break;
          end
        end
      end
    end
    res.count = heap_used[6:0];
    res.empty = (heap_used == 0);
    return res;
  endfunction

  // one directed row, expected result optional
  task automatic add_row(logic req, logic signed [15:0] prio, logic [31:0] data,
                         bit typed = 1'b0, logic [1:0] st = bmhq_pkg::ST_OK,
                         logic signed [15:0] oprio = '0, logic [31:0] odata = '0,
                         int cnt = 0);
    stim_row_t r;
    r.req = req;
    r.prio = prio;
    r.data = data;
    r.typed = typed;
    r.want.status = st;
    r.want.prio = oprio;
    r.want.data = odata;
    r.want.count = cnt[6:0];
    r.want.empty = (cnt == 0);
    directed_rows.push_back(r);
  endtask

  // drive one word and hold it until accepted
  task automatic send_word(logic req, logic signed [15:0] prio, logic [31:0] data,
                           bit typed, heap_result_t want);
    heap_result_t res;
    req_type    <= req;
    in_priority <= prio;
    in_payload  <= data;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    res = heap_apply(req, prio, data);
    pending_results.push_back(typed ? want : res);
  endtask

  // random sender gap, mostly short
  task automatic sender_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 55) len = 0;
    else if (pick < 88) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 40);
    if (len > 0) begin
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  // hold off until every expected result has come
  task automatic drain_pause();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // result checker
  always @(posedge clk) begin
    heap_result_t exp_res;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected result word: status=%0d prio=%0d data=%h count=%0d %s%0b",
                   status, out_priority, out_payload, entry_count, "empty=", is_empty);
      end else begin
        exp_res = pending_results.pop_front();
        if (status !== exp_res.status || out_priority !== exp_res.prio ||
            out_payload !== exp_res.data || entry_count !== exp_res.count ||
            is_empty !== exp_res.empty) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: expected status=%0d prio=%0d data=%h count=%0d empty=%0b,",
                     exp_res.status, exp_res.prio, exp_res.data, exp_res.count,
                     exp_res.empty);
            $display("          got status=%0d prio=%0d data=%h count=%0d empty=%0b",
                     status, out_priority, out_payload, entry_count, is_empty);
          end
        end
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("binary_min_heap_queue_tb: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus
  initial begin
    heap_result_t none;
    stim_row_t    r;
    int           sent;
    int           phase_len;
    int           ins_pct;
    int           phase_idx;
    logic               req;
    logic signed [15:0] prio;
    logic [31:0]        data;
    int                 ins_mix [5];

    none = '{default: '0};
    ins_mix = '{88, 12, 50, 96, 4};

    // empty, extremes and rejects have their results typed in
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0, 1'b1, bmhq_pkg::ST_EMPTY,
            16'sd0, 32'h0, 0);
    add_row(bmhq_pkg::REQ_INSERT, 16'sd32767, 32'hFFFF_FFFF, 1'b1, bmhq_pkg::ST_OK,
            16'sd0, 32'h0, 1);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sh1234, 32'h1234_5678, 1'b1, bmhq_pkg::ST_OK,
            16'sd32767, 32'hFFFF_FFFF, 0);
    add_row(bmhq_pkg::REQ_REMOVE, -16'sd32768, 32'hFFFF_FFFF, 1'b1, bmhq_pkg::ST_EMPTY,
            16'sd0, 32'h0, 0);
    add_row(bmhq_pkg::REQ_INSERT, -16'sd32768, 32'h0, 1'b1, bmhq_pkg::ST_OK,
            16'sd0, 32'h0, 1);
    // mixed keys with ties, drained in order
    add_row(bmhq_pkg::REQ_INSERT, 16'sd0, 32'hA5A5_A5A5);
    add_row(bmhq_pkg::REQ_INSERT, 16'sd7, 32'h0000_0001);
    add_row(bmhq_pkg::REQ_INSERT, 16'sd7, 32'h0000_0002);
    add_row(bmhq_pkg::REQ_INSERT, 16'sd7, 32'h0000_0003);
    add_row(bmhq_pkg::REQ_INSERT, -16'sd1, 32'h5A5A_5A5A);
    add_row(bmhq_pkg::REQ_INSERT, 16'sd32767, 32'h0);
    add_row(bmhq_pkg::REQ_INSERT, -16'sd32768, 32'h8000_0001);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sh7FFF, 32'hFFFF_FFFF);
    add_row(bmhq_pkg::REQ_REMOVE, -16'sd32768, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0);
    add_row(bmhq_pkg::REQ_REMOVE, 16'sd0, 32'h0, 1'b1, bmhq_pkg::ST_EMPTY,
            16'sd0, 32'h0, 0);

    // reset
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      sender_gap();
      send_word(r.req, r.prio, r.data, r.typed, r.want);
    end
    drain_pause();

    // random phases that lean toward filling, draining or churning the heap
    sent = 0;
    phase_idx = 0;
    while (sent < RANDOM_WORDS) begin
      ins_pct = ins_mix[phase_idx % 5];
      phase_len = $urandom_range(80, 160);
      for (int k = 0; k < phase_len && sent < RANDOM_WORDS; k++) begin
        req = ($urandom_range(0, 99) < ins_pct) ? bmhq_pkg::REQ_INSERT
                                                : bmhq_pkg::REQ_REMOVE;
        case ($urandom_range(0, 3))
          0: prio = $signed(16'($urandom_range(0, 7)) - 16'd4);
          1: begin
            case ($urandom_range(0, 3))
              0: prio = -16'sd32768;
              1: prio = 16'sd32767;
              2: prio = 16'sd0;
              default: prio = -16'sd1;
            endcase
          end
          default: prio = $signed(16'($urandom));
        endcase
        data = $urandom;
        sender_gap();
        send_word(req, prio, data, 1'b0, none);
        sent++;
      end
      // let every pending result come in between phases
      drain_pause();
      phase_idx++;
    end

    // wait out the last results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (fault_count == 0) begin
      $display("binary_min_heap_queue_tb: done, clean");
    end else begin
      $display("binary_min_heap_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
